[sv/pftd_pkg.sv]
// Package for the pixel fade, tint and dither chain.
// Holds the payload structs, register and dither codes, and the shared arithmetic helpers.
// No dependencies.
package pftd_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] FadeUnity = 8'd255;
  localparam logic [7:0] DitherDark = 8'd220;
  localparam logic [8:0] Q8One = 9'd256;
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef enum logic [2:0] {
    REG_FX_ENABLE   = 3'd0,
    REG_FLASH_ON    = 3'd1,
    REG_FLASH_COLOR = 3'd2,
    REG_FADE_SCALE  = 3'd3,
    REG_TINT_WEIGHT = 3'd4,
    REG_TINT_COLOR  = 3'd5,
    REG_DITHER_MODE = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    DITHER_NONE     = 3'd0,
    DITHER_BAYER2   = 3'd1,
    DITHER_BAYER4   = 3'd2,
    DITHER_CHECKER  = 3'd3,
    DITHER_HLINES   = 3'd4,
    DITHER_VLINES   = 3'd5,
    DITHER_DIAGONAL = 3'd6
  } dither_mode_e;

  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic       flash_on;
    logic [7:0] fade_factor;
    logic [8:0] tint_weight;
  } lane_ctl_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic       mask;
  } stage_ctl_t;

  localparam logic [1:0] BAYER2 [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};
  localparam logic [3:0] BAYER4 [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // Exact floor(x / 255) for every product of two bytes.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic dither_mask(input logic [2:0] mode, input logic [7:0] x,
                                       input logic [7:0] y);
    logic [1:0] s;
    logic       m;
    s = x[1:0] + y[1:0];
    case (dither_mode_e'(mode))
      DITHER_BAYER2:   m = BAYER2[y[0]][x[0]] >= 2'd2;
      DITHER_BAYER4:   m = BAYER4[y[1:0]][x[1:0]] >= 4'd8;
      DITHER_CHECKER:  m = s[0];
      DITHER_HLINES:   m = y[0];
      DITHER_VLINES:   m = x[0];
      DITHER_DIAGONAL: m = s[1];
      default:         m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

[sv/pixel_fade_tint_dither_chain.sv]
// Top level of the pixel fade, tint and dither chain with its register port.
// Depends on pftd_pkg and pftd_lane.
// The block takes one pixel per clock unless the output stalls; the four register
// stages (flash and fade multiply, fade divide and tint multiply, tint shift and darkening
// multiply, darkening divide into the output register) all advance together, so a stall on
// the output holds the whole pipeline and in_stall_o follows out_stall_i while a result waits.
// Registers must only be written while no transaction is in flight.
module pixel_fade_tint_dither_chain import pftd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pix_out_t             out_data_o
);

  logic        fx_enable_q;
  logic        flash_on_q;
  logic [23:0] flash_color_q;
  logic [7:0]  fade_scale_q;
  logic [8:0]  tint_weight_q;
  logic [23:0] tint_color_q;
  logic [2:0]  dither_mode_q;

  logic       wr_en;
  reg_idx_e   wr_idx;
  logic       en;
  logic       v1_q, v2_q, v3_q, out_valid_q;
  stage_ctl_t ctl_d, ctl1_q, ctl2_q, ctl3_q;
  logic [7:0] alpha_q;
  lane_ctl_t  lane_ctl;
  logic       mask;
  logic       act;
  logic [8:0] w_eff;
  logic [7:0] red_c, green_c, blue_c;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_enable_q   <= 1'b0;
      flash_on_q    <= 1'b0;
      flash_color_q <= '0;
      fade_scale_q  <= FadeUnity;
      tint_weight_q <= '0;
      tint_color_q  <= '0;
      dither_mode_q <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_FX_ENABLE:   fx_enable_q   <= pwdata[0];
        REG_FLASH_ON:    flash_on_q    <= pwdata[0];
        REG_FLASH_COLOR: flash_color_q <= pwdata[23:0];
        REG_FADE_SCALE:  fade_scale_q  <= pwdata[7:0];
        REG_TINT_WEIGHT: tint_weight_q <= pwdata[8:0];
        REG_TINT_COLOR:  tint_color_q  <= pwdata[23:0];
        REG_DITHER_MODE: dither_mode_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_FX_ENABLE:   prdata = {31'd0, fx_enable_q};
      REG_FLASH_ON:    prdata = {31'd0, flash_on_q};
      REG_FLASH_COLOR: prdata = {8'd0, flash_color_q};
      REG_FADE_SCALE:  prdata = {24'd0, fade_scale_q};
      REG_TINT_WEIGHT: prdata = {23'd0, tint_weight_q};
      REG_TINT_COLOR:  prdata = {8'd0, tint_color_q};
      REG_DITHER_MODE: prdata = {29'd0, dither_mode_q};
      default:         prdata = '0;
    endcase
  end

  // With effects off every stage runs with neutral factors and returns the channel unchanged.
  always_comb begin
    w_eff = (tint_weight_q > Q8One) ? Q8One : tint_weight_q;
    lane_ctl.flash_on = fx_enable_q && flash_on_q;
    lane_ctl.fade_factor = fx_enable_q ? fade_scale_q : FadeUnity;
    lane_ctl.tint_weight = fx_enable_q ? w_eff : 9'd0;
    mask = fx_enable_q && dither_mask(dither_mode_q, in_data_i.pos_x, in_data_i.pos_y);
    act = mask || lane_ctl.flash_on || (lane_ctl.fade_factor != FadeUnity) ||
          (lane_ctl.tint_weight != 9'd0);
    ctl_d.alpha = act ? AlphaOpaque : in_data_i.alpha_in;
    ctl_d.mask = mask;
  end

  assign en = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl1_q  <= ctl_d;
      ctl2_q  <= ctl1_q;
      ctl3_q  <= ctl2_q;
      alpha_q <= ctl3_q.alpha;
    end
  end

  pftd_lane u_red (
    .clk_i     (clk_i),
    .en_i      (en),
    .ctl_i     (lane_ctl),
    .flash_c_i (flash_color_q[23:16]),
    .tint_c_i  (tint_color_q[23:16]),
    .dark_i    (ctl2_q.mask),
    .c_i       (in_data_i.red_in),
    .c_o       (red_c)
  );

  pftd_lane u_green (
    .clk_i     (clk_i),
    .en_i      (en),
    .ctl_i     (lane_ctl),
    .flash_c_i (flash_color_q[15:8]),
    .tint_c_i  (tint_color_q[15:8]),
    .dark_i    (ctl2_q.mask),
    .c_i       (in_data_i.green_in),
    .c_o       (green_c)
  );

  pftd_lane u_blue (
    .clk_i     (clk_i),
    .en_i      (en),
    .ctl_i     (lane_ctl),
    .flash_c_i (flash_color_q[7:0]),
    .tint_c_i  (tint_color_q[7:0]),
    .dark_i    (ctl2_q.mask),
    .c_i       (in_data_i.blue_in),
    .c_o       (blue_c)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o.alpha_out = alpha_q;
  assign out_data_o.red_out = red_c;
  assign out_data_o.green_out = green_c;
  assign out_data_o.blue_out = blue_c;

endmodule

[sv/pftd_lane.sv]
// One colour channel of the effect pipeline: flash, fade, tint and darkening.
// Four register stages advance together on the enable; depends on pftd_pkg.
module pftd_lane import pftd_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  lane_ctl_t  ctl_i,
  input  logic [7:0] flash_c_i,
  input  logic [7:0] tint_c_i,
  input  logic       dark_i,
  input  logic [7:0] c_i,
  output logic [7:0] c_o
);

  logic [8:0]  flash_sum;
  logic [7:0]  flash_c;
  logic [15:0] fade_d, fade_q;
  logic [7:0]  faded;
  logic [15:0] tint_d, tint_q;
  logic [7:0]  tinted;
  logic [15:0] dark_d, dark_q;
  logic [7:0]  out_d, out_q;

  always_comb begin
    flash_sum = {1'b0, c_i} + {1'b0, flash_c_i};
    flash_c = ctl_i.flash_on ? flash_sum[8:1] : c_i;
    fade_d = 16'(flash_c) * 16'(ctl_i.fade_factor);
    faded = div255(fade_q);
    tint_d = 16'(faded) * 16'(Q8One - ctl_i.tint_weight) +
             16'(tint_c_i) * 16'(ctl_i.tint_weight);
    tinted = tint_q[15:8];
    dark_d = 16'(tinted) * 16'(dark_i ? DitherDark : FadeUnity);
    out_d = div255(dark_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fade_q <= fade_d;
      tint_q <= tint_d;
      dark_q <= dark_d;
      out_q  <= out_d;
    end
  end

  assign c_o = out_q;

endmodule

[sv/pftd_checker.sv]
// Port-level checker for the pixel fade, tint and dither chain, bound to its top level.
// Depends on pixel_fade_tint_dither_chain.
module pftd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // The input is held back only while a finished result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the output could move");

  // Free cycles without new transactions drain the pipeline completely.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i) ##1
    (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i) |=> !out_valid_o)
    else $error("result appeared without an input transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result withdrawn");

endmodule

bind pixel_fade_tint_dither_chain pftd_checker u_pftd_checker (.*);
